/* hw/rtl/sdvt_pkg.sv */
// Shared types and constants for the SQL dump values tokenizer.
package sdvt_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_TEXT,
        PH_ESC,
        PH_AFTER,
        PH_LEAD,
        PH_SIGNED,
        PH_BODY,
        PH_SKIP
    } t_phase;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TXT,
        OP_TXT_END,
        OP_REC_END,
        OP_ERR_UNEXP,
        OP_SIGN,
        OP_ICHAR,
        OP_IEND,
        OP_IEND_REC
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_TEXT     = 3'd0,
        KIND_TEXT_END = 3'd1,
        KIND_INT      = 3'd2,
        KIND_REC_END  = 3'd3,
        KIND_ERR      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NO_DIGITS  = 2'd0,
        ERR_OVERFLOW   = 2'd1,
        ERR_UNEXPECTED = 2'd2
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         text_byte;
        logic signed [63:0] value;
        t_err               err;
        logic               last;
    } t_result;

    // depth must be a power of two (pointers wrap)
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    localparam logic [7:0] CODE_NUL = 8'd0;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_SUB = 8'd26;

    localparam logic [67:0] LIMIT_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] LIMIT_NEG = 68'h0_8000_0000_0000_0000;

endpackage

/* hw/rtl/sdvt_front.sv */
// Front end: byte classifier and field phase state machine.
module sdvt_front import sdvt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output t_cmd       o_cmd
);

    t_phase r_phase, n_phase;

    logic is_quote, is_bslash, is_comma, is_lparen, is_rparen, is_sign, is_space;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        unique case (c)
            CH_ZERO:  unescape = CODE_NUL;
            CH_LOW_B: unescape = CODE_BS;
            CH_LOW_N: unescape = CODE_LF;
            CH_LOW_R: unescape = CODE_CR;
            CH_LOW_T: unescape = CODE_TAB;
            CH_UP_Z:  unescape = CODE_SUB;
            default:  unescape = c;
        endcase
    endfunction

    assign is_quote  = (i_byte == CH_QUOTE);
    assign is_bslash = (i_byte == CH_BSLASH);
    assign is_comma  = (i_byte == CH_COMMA);
    assign is_lparen = (i_byte == CH_LPAREN);
    assign is_rparen = (i_byte == CH_RPAREN);
    assign is_sign   = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    assign is_space  = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_START, PH_LEAD: begin
                if (r_phase == PH_START && is_quote) begin
                    n_phase = PH_TEXT;
                end else if (is_comma) begin
                    n_phase = PH_START;
                end else if (is_rparen) begin
                    n_phase = PH_SKIP;
                end else if (is_space) begin
                    n_phase = PH_LEAD;
                end else if (is_sign) begin
                    n_phase = PH_SIGNED;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_SIGNED, PH_BODY: begin
                if (is_comma) begin
                    n_phase = PH_START;
                end else if (is_rparen) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_TEXT: begin
                if (is_bslash) begin
                    n_phase = PH_ESC;
                end else if (is_quote) begin
                    n_phase = PH_AFTER;
                end
            end
            PH_ESC: n_phase = PH_TEXT;
            PH_AFTER: begin
                if (is_comma) begin
                    n_phase = PH_START;
                end else if (is_rparen) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (is_lparen) begin
                    n_phase = PH_START;
                end
            end
            default: n_phase = PH_START;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.data = i_byte;
        unique case (r_phase)
            PH_START, PH_LEAD: begin
                if (r_phase == PH_START && is_quote) begin
                    o_cmd.op = OP_NONE;
                end else if (is_comma) begin
                    o_cmd.op = OP_IEND;
                end else if (is_rparen) begin
                    o_cmd.op = OP_IEND_REC;
                end else if (is_space) begin
                    o_cmd.op = OP_NONE;
                end else if (is_sign) begin
                    o_cmd.op = OP_SIGN;
                end else begin
                    o_cmd.op = OP_ICHAR;
                end
            end
            PH_SIGNED, PH_BODY: begin
                if (is_comma) begin
                    o_cmd.op = OP_IEND;
                end else if (is_rparen) begin
                    o_cmd.op = OP_IEND_REC;
                end else begin
                    o_cmd.op = OP_ICHAR;
                end
            end
            PH_TEXT: begin
                if (is_quote) begin
                    o_cmd.op = OP_TXT_END;
                end else if (!is_bslash) begin
                    o_cmd.op = OP_TXT;
                end
            end
            PH_ESC: begin
                o_cmd.op   = OP_TXT;
                o_cmd.data = unescape(i_byte);
            end
            PH_AFTER: begin
                if (is_rparen) begin
                    o_cmd.op = OP_REC_END;
                end else if (!is_comma) begin
                    o_cmd.op = OP_ERR_UNEXP;
                end
            end
            PH_SKIP: o_cmd.op = OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
        end else if (i_valid) begin
            r_phase <= n_phase;
        end
    end

endmodule

/* hw/rtl/sdvt_cmdq.sv */
// Command queue between front end and back end.
module sdvt_cmdq import sdvt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   r_wr, r_rd;
    logic [CMDQ_AW:0]     r_count, n_count;

    assign o_full  = (r_count == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/sdvt_back.sv */
// Back end: integer accumulator, result builder and two-entry result buffer.
module sdvt_back import sdvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_pop,
    output logic    o_res_empty,
    output t_result o_res
);

    logic         r_neg, n_neg;
    logic [63:0]  r_mag, n_mag;
    logic         r_seen, n_seen;
    logic         r_closed, n_closed;
    logic         r_ovf, n_ovf;
    logic         r_rec_pend, n_rec_pend;

    t_result      r_oq [2];
    logic         r_owr, r_ord;
    logic [1:0]   r_ocnt;

    logic         room, needs_out, go, res_wr, is_digit;
    logic [67:0]  prod, limit;
    t_result      res, int_res;

    assign room      = (r_ocnt != 2'd2) || i_res_pop;
    assign needs_out = !(i_cmd.op == OP_SIGN || i_cmd.op == OP_ICHAR);
    assign go        = i_cmd_valid && (!needs_out || room);
    assign is_digit  = (i_cmd.data >= CH_ZERO) && (i_cmd.data <= CH_NINE);

    // mag * 10 + digit, compared against the signed range limit
    assign prod  = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {64'b0, i_cmd.data[3:0]};
    assign limit = r_neg ? LIMIT_NEG : LIMIT_POS;

    always_comb begin
        int_res = '0;
        if (!r_seen) begin
            int_res.kind = KIND_ERR;
            int_res.err  = ERR_NO_DIGITS;
        end else if (r_ovf) begin
            int_res.kind = KIND_ERR;
            int_res.err  = ERR_OVERFLOW;
        end else begin
            int_res.kind  = KIND_INT;
            int_res.value = r_neg ? -$signed(r_mag) : $signed(r_mag);
        end
    end

    always_comb begin
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_seen     = r_seen;
        n_closed   = r_closed;
        n_ovf      = r_ovf;
        n_rec_pend = r_rec_pend;
        res        = '0;
        res.last   = 1'b1;
        res_wr     = 1'b0;
        o_cmd_pop  = 1'b0;
        if (go) begin
            o_cmd_pop = 1'b1;
            case (i_cmd.op)
                OP_TXT: begin
                    res.kind      = KIND_TEXT;
                    res.text_byte = i_cmd.data;
                    res_wr        = 1'b1;
                end
                OP_TXT_END: begin
                    res.kind = KIND_TEXT_END;
                    res_wr   = 1'b1;
                end
                OP_REC_END: begin
                    res.kind = KIND_REC_END;
                    res_wr   = 1'b1;
                end
                OP_ERR_UNEXP: begin
                    res.kind = KIND_ERR;
                    res.err  = ERR_UNEXPECTED;
                    res_wr   = 1'b1;
                end
                OP_SIGN: begin
                    n_neg = (i_cmd.data == CH_MINUS);
                end
                OP_ICHAR: begin
                    if (!r_closed && is_digit) begin
                        n_seen = 1'b1;
                        if (!r_ovf) begin
                            if (prod > limit) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_mag = prod[63:0];
                            end
                        end
                    end else begin
                        n_closed = 1'b1;
                    end
                end
                OP_IEND, OP_IEND_REC: begin
                    if (i_cmd.op == OP_IEND_REC && r_rec_pend) begin
                        res.kind   = KIND_REC_END;
                        n_rec_pend = 1'b0;
                    end else begin
                        res        = int_res;
                        res.last   = (i_cmd.op == OP_IEND);
                        n_neg      = 1'b0;
                        n_mag      = '0;
                        n_seen     = 1'b0;
                        n_closed   = 1'b0;
                        n_ovf      = 1'b0;
                        if (i_cmd.op == OP_IEND_REC) begin
                            n_rec_pend = 1'b1;
                            o_cmd_pop  = 1'b0;
                        end
                    end
                    res_wr = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_res_empty = (r_ocnt == 2'd0);
    assign o_res       = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_oq[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg      <= 1'b0;
            r_mag      <= '0;
            r_seen     <= 1'b0;
            r_closed   <= 1'b0;
            r_ovf      <= 1'b0;
            r_rec_pend <= 1'b0;
            r_owr      <= 1'b0;
            r_ord      <= 1'b0;
            r_ocnt     <= '0;
        end else begin
            r_neg      <= n_neg;
            r_mag      <= n_mag;
            r_seen     <= n_seen;
            r_closed   <= n_closed;
            r_ovf      <= n_ovf;
            r_rec_pend <= n_rec_pend;
            if (res_wr) begin
                r_owr <= ~r_owr;
            end
            if (i_res_pop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + {1'b0, res_wr} - {1'b0, i_res_pop};
        end
    end

endmodule

/* hw/rtl/sql_dump_values_tokenizer_top.sv */
// A byte's first result goes through the command queue, then the result buffer, to the ports.
// Throughput: one byte per cycle unless full; the back end writes one result per cycle
// when it has room; a ')' after an integer field (two results) holds it for both.
// Input side stalls only when the four-entry command queue fills behind a stalled output.
// Reset: synchronous, active low; clears phase, command queue, result buffer and integer state.
// Top level of the SQL dump values tokenizer.
module sql_dump_values_tokenizer_top import sdvt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_token_kind,
    output logic [7:0]         o_text_byte,
    output logic signed [63:0] o_int_value,
    output logic [1:0]         o_error_code,
    output logic               o_last_of_run
);

    logic    accept, q_push, q_valid, q_pop, res_pop;
    t_cmd    f_cmd, q_cmd;
    t_result res;

    assign accept  = push && !full;
    assign q_push  = accept && (f_cmd.op != OP_NONE);
    assign res_pop = pop && !empty;

    sdvt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_byte  (i_data_byte),
        .o_cmd   (f_cmd)
    );

    sdvt_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    sdvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_res_pop   (res_pop),
        .o_res_empty (empty),
        .o_res       (res)
    );

    assign o_token_kind  = res.kind;
    assign o_text_byte   = res.text_byte;
    assign o_int_value   = res.value;
    assign o_error_code  = res.err;
    assign o_last_of_run = res.last;

    a_text_only_on_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != KIND_TEXT) |-> (o_text_byte == 8'd0))
        else $error("text byte set on a non-text item");

    a_value_only_on_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != KIND_INT) |-> (o_int_value == 64'sd0))
        else $error("integer value set on a non-integer item");

    a_err_only_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind != KIND_ERR) |-> (o_error_code == ERR_NO_DIGITS))
        else $error("error code set on a non-error item");

    a_int_before_rec_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_of_run) |->
            (o_token_kind == KIND_INT || o_token_kind == KIND_ERR))
        else $error("only an integer field result may precede a record end");

    a_reset_clears: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (empty && !full))
        else $error("queues not empty after reset");

endmodule

/* test/sdvt_token_check.sv */
`timescale 1ns / 100ps
// Token predictor and result comparison for the SQL dump values tokenizer.
module sdvt_token_check import sdvt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [2:0]         i_token_kind,
    input  logic [7:0]         i_text_byte,
    input  logic signed [63:0] i_int_value,
    input  logic [1:0]         i_error_code,
    input  logic               i_last_of_run,
    output int                 o_pending,
    output int                 o_fail_count
);

    t_result     expected_tokens[$];
    t_result     oldest;
    t_phase      phase;
    logic        neg;
    logic [63:0] mag;
    logic        seen;
    logic        closed;
    logic        ovf;
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    // error code reads zero (ERR_NO_DIGITS) on tokens that are not errors
    task automatic emit(input t_kind kind, input logic [7:0] chr, input logic [63:0] val,
                        input t_err err);
        t_result r;
        r.kind      = kind;
        r.text_byte = chr;
        r.value     = val;
        r.err       = err;
        r.last      = 1'b0;
        expected_tokens = {expected_tokens, r};
    endtask

    task automatic clear_int();
        neg    = 1'b0;
        mag    = 64'd0;
        seen   = 1'b0;
        closed = 1'b0;
        ovf    = 1'b0;
    endtask

    task automatic close_int();
        if (!seen) begin
            emit(KIND_ERR, 8'd0, 64'd0, ERR_NO_DIGITS);
        end else if (ovf) begin
            emit(KIND_ERR, 8'd0, 64'd0, ERR_OVERFLOW);
        end else begin
            emit(KIND_INT, 8'd0, neg ? 64'd0 - mag : mag, ERR_NO_DIGITS);
        end
        clear_int();
    endtask

    task automatic tokenize_byte(input logic [7:0] c);
        logic [63:0] dig;
        logic [63:0] lim;
        logic [7:0]  ch;
        int          n0;
        n0 = expected_tokens.size();
        case (phase)
            PH_TEXT: begin
                if (c == CH_BSLASH) begin
                    phase = PH_ESC;
                end else if (c == CH_QUOTE) begin
                    emit(KIND_TEXT_END, 8'd0, 64'd0, ERR_NO_DIGITS);
                    phase = PH_AFTER;
                end else begin
                    emit(KIND_TEXT, c, 64'd0, ERR_NO_DIGITS);
                end
            end
            PH_ESC: begin
                case (c)
                    CH_ZERO:  ch = CODE_NUL;
                    CH_LOW_B: ch = CODE_BS;
                    CH_LOW_N: ch = CODE_LF;
                    CH_LOW_R: ch = CODE_CR;
                    CH_LOW_T: ch = CODE_TAB;
                    CH_UP_Z:  ch = CODE_SUB;
                    default:  ch = c;
                endcase
                emit(KIND_TEXT, ch, 64'd0, ERR_NO_DIGITS);
                phase = PH_TEXT;
            end
            PH_AFTER: begin
                if (c == CH_COMMA) begin
                    phase = PH_START;
                end else if (c == CH_RPAREN) begin
                    emit(KIND_REC_END, 8'd0, 64'd0, ERR_NO_DIGITS);
                    phase = PH_SKIP;
                end else begin
                    emit(KIND_ERR, 8'd0, 64'd0, ERR_UNEXPECTED);
                end
            end
            PH_SKIP: begin
                if (c == CH_LPAREN) phase = PH_START;
            end
            default: begin
                if (phase == PH_START && c == CH_QUOTE) begin
                    phase = PH_TEXT;
                end else begin
                    if (phase == PH_START) begin
                        clear_int();
                        phase = PH_LEAD;
                    end
                    if (c == CH_COMMA) begin
                        close_int();
                        phase = PH_START;
                    end else if (c == CH_RPAREN) begin
                        close_int();
                        emit(KIND_REC_END, 8'd0, 64'd0, ERR_NO_DIGITS);
                        phase = PH_SKIP;
                    end else if (phase == PH_LEAD &&
                                 (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                        // whitespace ahead of the sign
                    end else if (phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                        neg   = (c == CH_MINUS);
                        phase = PH_SIGNED;
                    end else if (!closed && c >= CH_ZERO && c <= CH_NINE) begin
                        dig  = 64'(c - CH_ZERO);
                        lim  = neg ? LIMIT_NEG[63:0] : LIMIT_POS[63:0];
                        seen = 1'b1;
                        if (!ovf) begin
                            if (mag > (lim - dig) / 64'd10) ovf = 1'b1;
                            else mag = mag * 64'd10 + dig;
                        end
                        phase = PH_BODY;
                    end else begin
                        closed = 1'b1;
                        phase  = PH_BODY;
                    end
                end
            end
        endcase
        if (expected_tokens.size() > n0) expected_tokens[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_tokens.delete();
            phase = PH_START;
            clear_int();
            o_pending <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected token", 64'(i_token_kind), 64'd0);
                end else begin
                    oldest = expected_tokens.pop_front();
                    if (i_token_kind !== oldest.kind)
                        report_mismatch("token_kind", 64'(i_token_kind), 64'(oldest.kind));
                    if (i_text_byte !== oldest.text_byte)
                        report_mismatch("text_byte", 64'(i_text_byte), 64'(oldest.text_byte));
                    if (i_int_value !== oldest.value)
                        report_mismatch("int_value", i_int_value, oldest.value);
                    if (i_error_code !== oldest.err)
                        report_mismatch("error_code", 64'(i_error_code), 64'(oldest.err));
                    if (i_last_of_run !== oldest.last)
                        report_mismatch("last_of_run", 64'(i_last_of_run), 64'(oldest.last));
                end
            end
            if (i_push && !i_full) tokenize_byte(i_data_byte);
            o_pending <= expected_tokens.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Stimulus, clock, watchdog and verdict for the SQL dump values tokenizer.
module tb;
    import sdvt_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int ITEM_TARGET = 950;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_data_byte;
    logic               empty;
    logic               pop;
    logic [2:0]         o_token_kind;
    logic [7:0]         o_text_byte;
    logic signed [63:0] o_int_value;
    logic [1:0]         o_error_code;
    logic               o_last_of_run;

    int         pending;
    int         fail_count;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         rx_hold_left = 0;
    int         sent = 0;
    int         stall_cycles = 0;
    logic [7:0] dump_bytes[$];

    sql_dump_values_tokenizer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_token_kind  (o_token_kind),
        .o_text_byte   (o_text_byte),
        .o_int_value   (o_int_value),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    sdvt_token_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_data_byte   (i_data_byte),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_token_kind  (o_token_kind),
        .i_text_byte   (o_text_byte),
        .i_int_value   (o_int_value),
        .i_error_code  (o_error_code),
        .i_last_of_run (o_last_of_run),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random idling, plus a long hold-off when requested
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        dump_bytes = {dump_bytes, b};
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++) queue_byte(s[k]);
    endtask

    task automatic add_text_field();
        logic [7:0] b;
        queue_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 4) == 0) begin
                queue_byte(CH_BSLASH);
                if ($urandom_range(0, 1)) begin
                    case ($urandom_range(0, 5))
                        0:       b = CH_ZERO;
                        1:       b = CH_LOW_B;
                        2:       b = CH_LOW_N;
                        3:       b = CH_LOW_R;
                        4:       b = CH_LOW_T;
                        default: b = CH_UP_Z;
                    endcase
                end
            end
            queue_byte(b);
        end
        queue_byte(CH_QUOTE);
    endtask

    task automatic add_int_field();
        string      s;
        longint     v;
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(CH_TAB, CH_CR));
                if ($urandom_range(0, 5) == 0) b = CH_SPACE;
                queue_byte(b);
            end
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                s = $urandom_range(0, 1) ? "-" : ($urandom_range(0, 3) == 0 ? "+" : "");
                if ($urandom_range(0, 5) == 0) s = {s, "00"};
                s = $sformatf("%s%0d", s, $urandom_range(0, 99999));
            end
            4: begin
                v = {$urandom, $urandom};
                s = $sformatf("%0d", v);
            end
            5: s = $urandom_range(0, 1) ? "+9223372036854775807" : "9223372036854775807";
            6: s = "-9223372036854775808";
            7: s = $urandom_range(0, 1) ? "9223372036854775808" : "-9223372036854775809";
            8: begin
                s = $urandom_range(0, 1) ? "-" : "";
                repeat ($urandom_range(20, 24)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       s = "";
                    1:       s = "+";
                    2:       s = "-";
                    3:       s = "- 5";
                    default: s = "q1";
                endcase
            end
        endcase
        if ($urandom_range(0, 4) == 0) begin
            s = $urandom_range(0, 1) ? $sformatf("%s %0d", s, $urandom_range(0, 99))
                                     : {s, "x+"};
        end
        add_str(s);
    endtask

    task automatic add_record();
        int         nf;
        logic [7:0] b;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) queue_byte(CH_COMMA);
            if ($urandom_range(0, 1)) add_text_field();
            else add_int_field();
            if ($urandom_range(0, 14) == 0) queue_byte(8'($urandom_range(0, 255)));
        end
        queue_byte(CH_RPAREN);
        repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LPAREN) b = CH_SPACE;
            queue_byte(b);
        end
        queue_byte(CH_LPAREN);
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    task automatic send_records_until(input int count);
        while (sent < count) begin
            if (dump_bytes.size() == 0) add_record();
            send_byte(dump_bytes.pop_front());
        end
    endtask

    // stop offering and wait for every expected token
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        push        = 1'b0;
        i_data_byte = 8'd0;
        i_rst_n     = 1'b0;
        tx_idle_pct = 8;
        rx_idle_pct = 48;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // escapes, byte extremes, junk after text, empty field, sign forms, skip
        add_str("'\\0\\b\\n\\r\\t\\Z\\q");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        add_str("'x,, +7z,+ 7)s(-0)(");
        while (dump_bytes.size() > 0) send_byte(dump_bytes.pop_front());

        send_records_until(300);
        rx_hold_left = 400;
        send_records_until(380);
        drain();

        tx_idle_pct = 48;
        rx_idle_pct = 8;
        send_records_until(640);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_records_until(ITEM_TARGET);
        drain();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
